### rtl/c3_pkg.sv
// Shared types and codes for the 3x3 convolution block.
// No dependencies; c3_mac and the top level import this package.
`timescale 1ns / 1ps

package c3_pkg;

    localparam logic [1:0] ACT_WEIGHT  = 2'd0;
    localparam logic [1:0] ACT_BIAS    = 2'd1;
    localparam logic [1:0] ACT_PIXEL   = 2'd2;
    localparam logic [1:0] ACT_COMPUTE = 2'd3;

    localparam logic [1:0] CFG_IMG_HEIGHT   = 2'd0;
    localparam logic [1:0] CFG_IMG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_IN_CHANNELS  = 2'd2;
    localparam logic [1:0] CFG_OUT_CHANNELS = 2'd3;

    localparam int KTAPS   = 9;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int OUT_W   = 15;
    localparam int OUT_MAX = 32767;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // One issued tap: valid, zero padding, and accumulator clear.
    typedef struct packed {
        logic valid;
        logic pad;
        logic clear;
    } t_mac_ctl;

endpackage

### rtl/c3_in_if.sv
// Input channel of the convolution block: valid/ready plus one item.
// Depends on nothing.
`timescale 1ns / 1ps

interface c3_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [15:0] value;
    logic [3:0]        out_chan;
    logic [3:0]        in_chan;
    logic [3:0]        tap;
    logic [4:0]        row;
    logic [4:0]        col;

    modport source (output valid, action, value, out_chan, in_chan, tap, row, col,
                    input ready);
    modport sink   (input valid, action, value, out_chan, in_chan, tap, row, col,
                    output ready);
endinterface

### rtl/c3_out_if.sv
// Result channel of the convolution block: valid/ready plus one result.
// Depends on nothing.
`timescale 1ns / 1ps

interface c3_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] out_value;
    logic [3:0]  res_chan;
    logic [4:0]  res_row;
    logic [4:0]  res_col;

    modport source (output valid, out_value, res_chan, res_row, res_col, input ready);
    modport sink   (input valid, out_value, res_chan, res_row, res_col, output ready);
endinterface

### rtl/c3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module c3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/c3_mac.sv
// Multiply-accumulate pipeline: one tap per cycle, product then accumulate.
// Depends on c3_pkg; data arrives from the stores in the cycle after the issue.
`timescale 1ns / 1ps

module c3_mac
    import c3_pkg::*;
#(
    parameter int ACC_W = 42
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic signed [VAL_W-1:0] i_weight,
    input  logic signed [VAL_W-1:0] i_pixel,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_busy
);
    t_mac_ctl                 r_s1;
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  w_pix;

    assign w_pix = r_s1.pad ? '0 : i_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1       <= i_ctl;
            r_s2_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_weight * w_pix;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_s1.valid | r_s2_valid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |-> !o_busy)
        else $error("accumulator cleared while taps are in flight");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |=> r_s2_valid)
        else $error("tap lost between pipeline stages");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(r_s1.valid))
        else $error("product stage valid without an issued tap");
endmodule

### rtl/conv3x3_same_pad_bias_relu.sv
// Top level of the 3x3 convolution block with zero padding, bias and ReLU.
// Depends on c3_pkg, c3_in_if, c3_out_if, c3_ram and c3_mac.
//
// Usage: items arrive on i_in. Actions load a weight, a bias or a pixel into
// the on-chip stores, or request one output pixel. Loads are accepted back to
// back while the block is idle and give no result. A compute item for
// output channel, row and column gives one result on o_out, or none if it
// lies outside the configured image or channel count. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
// A compute walks the 9 taps of every input channel, one tap per cycle
// through a single multiplier fed by the feature and weight memory read
// ports, then waits for the MAC pipeline to drain; the result becomes valid
// together with the input becoming ready again.
// The input is not ready while a compute is in progress. A finished result
// sits in the output register; while the receiver stalls, loads are still
// accepted, but the next compute cannot hand over its result until the
// waiting one is taken. Reset restores the default image size and channel
// counts and clears the handshakes; the stores hold no defined values until
// they are written.
`timescale 1ns / 1ps

module conv3x3_same_pad_bias_relu
    import c3_pkg::*;
#(
    parameter int MAX_H    = 32,
    parameter int MAX_W    = 32,
    parameter int MAX_CIN  = 16,
    parameter int MAX_COUT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c3_in_if.sink      i_in,
    c3_out_if.source   o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data
);
    localparam int FD    = MAX_CIN * MAX_H * MAX_W;
    localparam int WD    = MAX_COUT * MAX_CIN * KTAPS;
    localparam int FA_W  = $clog2(FD);
    localparam int WA_W  = $clog2(WD);
    localparam int BA_W  = (MAX_COUT > 1) ? $clog2(MAX_COUT) : 1;
    localparam int H_W   = $clog2(MAX_H + 1);
    localparam int W_W   = $clog2(MAX_W + 1);
    localparam int CN_W  = $clog2(MAX_CIN + 1);
    localparam int CO_W  = $clog2(MAX_COUT + 1);
    localparam int CI_W  = (MAX_CIN > 1) ? $clog2(MAX_CIN) : 1;
    localparam int ACC_W = PROD_W + $clog2(KTAPS * MAX_CIN + 1) + 2;

    t_state r_state, n_state;

    logic [5:0] r_img_height, r_img_width;
    logic [4:0] r_in_channels, r_out_channels;
    logic [H_W-1:0]  w_eff_h;
    logic [W_W-1:0]  w_eff_w;
    logic [CN_W-1:0] w_eff_ci;
    logic [CO_W-1:0] w_eff_co;

    logic [3:0] r_oc;
    logic [4:0] r_row, r_col;
    logic [CI_W-1:0] r_c;
    logic [3:0] r_t;
    logic [1:0] r_dy, r_dx;

    logic r_out_valid;
    logic [OUT_W-1:0] r_out_value;
    logic [3:0] r_res_chan;
    logic [4:0] r_res_row, r_res_col;

    logic w_accept, w_compute_ok, w_last, w_in_img, w_mac_busy, w_hand_out;
    logic [5:0] w_rp, w_cp;
    logic [FA_W-1:0] w_f_raddr, w_f_waddr;
    logic [WA_W-1:0] w_w_raddr, w_w_waddr;
    logic w_f_we, w_w_we, w_b_we;
    logic [VAL_W-1:0] w_f_rdata, w_w_rdata, w_b_rdata;
    t_mac_ctl w_ctl;
    logic signed [ACC_W-1:0] w_acc, w_total, w_shift;

    // Register values of zero count as one; values above the store size clip.
    assign w_eff_h  = (r_img_height == '0) ? H_W'(1) :
                      (32'(r_img_height) > MAX_H) ? H_W'(MAX_H) : H_W'(r_img_height);
    assign w_eff_w  = (r_img_width == '0) ? W_W'(1) :
                      (32'(r_img_width) > MAX_W) ? W_W'(MAX_W) : W_W'(r_img_width);
    assign w_eff_ci = (r_in_channels == '0) ? CN_W'(1) :
                      (32'(r_in_channels) > MAX_CIN) ? CN_W'(MAX_CIN) : CN_W'(r_in_channels);
    assign w_eff_co = (r_out_channels == '0) ? CO_W'(1) :
                      (32'(r_out_channels) > MAX_COUT) ? CO_W'(MAX_COUT) : CO_W'(r_out_channels);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_height   <= 6'd32;
            r_img_width    <= 6'd32;
            r_in_channels  <= 5'd16;
            r_out_channels <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMG_HEIGHT:   r_img_height   <= i_cfg_data;
                CFG_IMG_WIDTH:    r_img_width    <= i_cfg_data;
                CFG_IN_CHANNELS:  r_in_channels  <= i_cfg_data[4:0];
                CFG_OUT_CHANNELS: r_out_channels <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_compute_ok = (32'(i_in.out_chan) < 32'(w_eff_co)) &&
                          (32'(i_in.row) < 32'(w_eff_h)) &&
                          (32'(i_in.col) < 32'(w_eff_w));

    // Store writes; loads outside the store size are dropped.
    assign w_w_we = w_accept && (i_in.action == ACT_WEIGHT) &&
                    (32'(i_in.out_chan) < MAX_COUT) && (32'(i_in.in_chan) < MAX_CIN) &&
                    (32'(i_in.tap) < KTAPS);
    assign w_b_we = w_accept && (i_in.action == ACT_BIAS) &&
                    (32'(i_in.out_chan) < MAX_COUT);
    assign w_f_we = w_accept && (i_in.action == ACT_PIXEL) &&
                    (32'(i_in.in_chan) < MAX_CIN) && (32'(i_in.row) < MAX_H) &&
                    (32'(i_in.col) < MAX_W);
    assign w_w_waddr = WA_W'((32'(i_in.out_chan) * MAX_CIN + 32'(i_in.in_chan)) * KTAPS
                             + 32'(i_in.tap));
    assign w_f_waddr = FA_W'((32'(i_in.in_chan) * MAX_H + 32'(i_in.row)) * MAX_W
                             + 32'(i_in.col));

    // Tap position: row+dy and col+dx are one above the source coordinates.
    assign w_rp = 6'(r_row) + 6'(r_dy);
    assign w_cp = 6'(r_col) + 6'(r_dx);
    assign w_in_img = (w_rp != '0) && (32'(w_rp) <= 32'(w_eff_h)) &&
                      (w_cp != '0) && (32'(w_cp) <= 32'(w_eff_w));
    assign w_f_raddr = FA_W'((32'(r_c) * MAX_H + 32'(w_rp) - 1) * MAX_W + 32'(w_cp) - 1);
    assign w_w_raddr = WA_W'((32'(r_oc) * MAX_CIN + 32'(r_c)) * KTAPS + 32'(r_t));
    assign w_last    = (r_t == 4'(KTAPS - 1)) && (32'(r_c) == 32'(w_eff_ci) - 1);

    assign w_ctl.valid = (r_state == ST_RUN);
    assign w_ctl.pad   = !w_in_img;
    assign w_ctl.clear = w_accept && (i_in.action == ACT_COMPUTE);

    c3_ram #(.WIDTH(VAL_W), .DEPTH(FD), .AW(FA_W)) u_feature (
        .i_clk(i_clk), .i_we(w_f_we), .i_waddr(w_f_waddr), .i_wdata(i_in.value),
        .i_raddr(w_f_raddr), .o_rdata(w_f_rdata)
    );
    c3_ram #(.WIDTH(VAL_W), .DEPTH(WD), .AW(WA_W)) u_weight (
        .i_clk(i_clk), .i_we(w_w_we), .i_waddr(w_w_waddr), .i_wdata(i_in.value),
        .i_raddr(w_w_raddr), .o_rdata(w_w_rdata)
    );
    c3_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COUT), .AW(BA_W)) u_bias (
        .i_clk(i_clk), .i_we(w_b_we), .i_waddr(BA_W'(i_in.out_chan)),
        .i_wdata(i_in.value), .i_raddr(BA_W'(r_oc)), .o_rdata(w_b_rdata)
    );

    c3_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_weight(w_w_rdata), .i_pixel(w_f_rdata),
        .o_acc(w_acc), .o_busy(w_mac_busy)
    );

    // Bias joins as Q16.16; floor shift back to Q8.8, then ReLU and saturation.
    assign w_total = w_acc + (ACC_W'($signed(w_b_rdata)) <<< 8);
    assign w_shift = w_total >>> 8;
    assign w_hand_out = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in.action == ACT_COMPUTE) && w_compute_ok) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_mac_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_hand_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_hand_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_oc  <= i_in.out_chan;
            r_row <= i_in.row;
            r_col <= i_in.col;
            r_c   <= '0;
            r_t   <= '0;
            r_dy  <= '0;
            r_dx  <= '0;
        end else if (r_state == ST_RUN) begin
            if (r_t == 4'(KTAPS - 1)) begin
                r_t  <= '0;
                r_dy <= '0;
                r_dx <= '0;
                r_c  <= r_c + 1'b1;
            end else begin
                r_t <= r_t + 1'b1;
                if (r_dx == 2'd2) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 1'b1;
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end
        end
        if (w_hand_out) begin
            r_out_value <= (w_total < 0) ? '0 :
                           (w_shift > ACC_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(w_shift);
            r_res_chan  <= r_oc;
            r_res_row   <= r_row;
            r_res_col   <= r_col;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.res_chan  = r_res_chan;
    assign o_out.res_row   = r_res_row;
    assign o_out.res_col   = r_res_col;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !w_mac_busy)
        else $error("result formed while taps are still in flight");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !(w_f_we || w_w_we || w_b_we))
        else $error("store written during a compute");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result presented without a finished compute");
endmodule
